@@ hdl/ptts_pkg.sv @@
// shared types and constants of the periodic task tick scheduler
package ptts_pkg;

   // default table geometry
   localparam int DEFAULT_LEVELS = 4;
   localparam int DEFAULT_SLOTS  = 4;

   // most firings reported by one tick
   localparam int MAX_RESULTS = 16;

   // countdown and period width
   localparam int DATA_W = 16;

   // memory write address width, wide enough for the largest table
   localparam int ADDR_W = 8;

   // request kinds
   typedef enum logic [2:0] {
      KIND_TICK    = 3'd0,
      KIND_CREATE  = 3'd1,
      KIND_DELETE  = 3'd2,
      KIND_SUSPEND = 3'd3,
      KIND_RESUME  = 3'd4,
      KIND_QUERY   = 3'd5
   } kind_type;

   // per entry task state codes
   typedef enum logic [1:0] {
      TS_READY     = 2'd0,
      TS_SUSPENDED = 2'd1,
      TS_DELETED   = 2'd2
   } task_state_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_CREATE,
      ST_REPLY
   } ctrl_state_type;

   // write port of the countdown and period memories
   typedef struct packed {
      logic              cd_en;
      logic              rp_en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] cd;
      logic [DATA_W-1:0] rp;
   } mem_wr_type;

endpackage

@@ hdl/ptts_count_unit.sv @@
// shared countdown unit: zero test and decrement or reload
module ptts_count_unit
   import ptts_pkg::*;
(
   input  logic [DATA_W-1:0] count_val,
   input  logic [DATA_W-1:0] reload_val,
   output logic              is_zero,
   output logic [DATA_W-1:0] next_val
);

   // one subtractor serves both the reload and the decrement
   logic [DATA_W-1:0] operand;

   assign is_zero  = (count_val == '0);
   assign operand  = is_zero ? reload_val : count_val;
   assign next_val = operand - DATA_W'(1);

endmodule

@@ hdl/ptts_task_mem.sv @@
// countdown and reload period memories, one write and one registered read
module ptts_task_mem
   import ptts_pkg::*;
#(
   parameter int ENTRIES = DEFAULT_LEVELS * DEFAULT_SLOTS,
   parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic              clock,
   input  mem_wr_type        wr,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [DATA_W-1:0] rd_cd,
   output logic [DATA_W-1:0] rd_rp
);

   logic [DATA_W-1:0] cd_mem [ENTRIES];
   logic [DATA_W-1:0] rp_mem [ENTRIES];

   // writes
   always_ff @(posedge clock) begin
      if (wr.cd_en) begin
         cd_mem[wr.addr[IDX_W-1:0]] <= wr.cd;
      end
      if (wr.rp_en) begin
         rp_mem[wr.addr[IDX_W-1:0]] <= wr.rp;
      end
   end

   // registered reads
   always_ff @(posedge clock) begin
      rd_cd <= cd_mem[rd_addr];
      rd_rp <= rp_mem[rd_addr];
   end

endmodule

@@ hdl/periodic_task_tick_scheduler_core.sv @@
// top level of the periodic task tick scheduler
// tick: busy during the one-entry-a-cycle table walk
//   through the single countdown memory port and the shared countdown unit
// create: busy while it scans the slots of the level; other kinds: busy through the reply state
// each result is registered and shows on the rsp_ ports in the cycle after the cycle that makes it
// reset: synchronous, all entries deleted and unallocated; countdown memory is not cleared
module periodic_task_tick_scheduler_core
   import ptts_pkg::*;
#(
   parameter int LEVELS          = DEFAULT_LEVELS,
   parameter int SLOTS_PER_LEVEL = DEFAULT_SLOTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_kind,
   input  logic [1:0]  req_level,
   input  logic [1:0]  req_slot,
   input  logic [15:0] req_period,
   input  logic [15:0] req_initial_delay,
   output logic        rsp_valid,
   output logic        rsp_fired,
   output logic [1:0]  rsp_fired_level,
   output logic [1:0]  rsp_fired_slot,
   output logic        rsp_accepted,
   output logic [1:0]  rsp_slot_state,
   output logic        rsp_last
);

   localparam int ENTRIES = LEVELS * SLOTS_PER_LEVEL;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int LV_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int SL_W    = (SLOTS_PER_LEVEL > 1) ? $clog2(SLOTS_PER_LEVEL) : 1;
   localparam int NREP_W  = $clog2(MAX_RESULTS + 1);
   localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(ENTRIES - 1);
   localparam logic [SL_W-1:0]   SL_LAST  = SL_W'(SLOTS_PER_LEVEL - 1);
   localparam logic [NREP_W-1:0] NREP_MAX = NREP_W'(MAX_RESULTS);

   // sequencer and captured request
   ctrl_state_type    state_ff, state_in;
   kind_type          kind_ff, kind_in;
   logic [1:0]        level_ff, level_in;
   logic [1:0]        slot_ff, slot_in;
   logic [DATA_W-1:0] period_ff, period_in;
   logic [DATA_W-1:0] delay_ff, delay_in;

   // walk issue stage
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [LV_W-1:0]   walk_lv_ff, walk_lv_in;
   logic [SL_W-1:0]   walk_sl_ff, walk_sl_in;
   logic              issue_done_ff, issue_done_in;

   // walk process stage
   logic              proc_valid_ff, proc_valid_in;
   logic [IDX_W-1:0]  proc_idx_ff, proc_idx_in;
   logic [LV_W-1:0]   proc_lv_ff, proc_lv_in;
   logic [SL_W-1:0]   proc_sl_ff, proc_sl_in;

   // held firing, sent once the next one or the walk end shows whether it is last
   logic              pend_valid_ff, pend_valid_in;
   logic [LV_W-1:0]   pend_lv_ff, pend_lv_in;
   logic [SL_W-1:0]   pend_sl_ff, pend_sl_in;
   logic [NREP_W-1:0] nrep_ff, nrep_in;

   // create slot scan
   logic [SL_W-1:0]   scan_ff, scan_in;

   // task table flags
   task_state_type    task_state_ff [ENTRIES];
   task_state_type    task_state_in [ENTRIES];
   logic              alloc_ff [ENTRIES];
   logic              alloc_in [ENTRIES];

   // result register
   logic              res_valid_ff, res_valid_in;
   logic              res_fired_ff, res_fired_in;
   logic [1:0]        res_lv_ff, res_lv_in;
   logic [1:0]        res_sl_ff, res_sl_in;
   logic              res_acc_ff, res_acc_in;
   logic [1:0]        res_state_ff, res_state_in;
   logic              res_last_ff, res_last_in;

   // memory and shared unit
   mem_wr_type        mem_wr;
   logic [DATA_W-1:0] rd_cd, rd_rp;
   logic              unit_zero;
   logic [DATA_W-1:0] unit_next;

   logic              accept;
   logic              level_ok;
   logic              query_ok;
   logic [IDX_W-1:0]  create_idx;
   logic [IDX_W-1:0]  query_idx;
   logic              create_done;
   logic              walk_end;

   ptts_task_mem #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_addr (idx_ff),
      .rd_cd   (rd_cd),
      .rd_rp   (rd_rp)
   );

   ptts_count_unit u_count (
      .count_val  (rd_cd),
      .reload_val (rd_rp),
      .is_zero    (unit_zero),
      .next_val   (unit_next)
   );

   // handshake and shared decode
   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign level_ok   = (32'(level_ff) < LEVELS);
   assign query_ok   = level_ok && (32'(slot_ff) < SLOTS_PER_LEVEL);
   assign create_idx = IDX_W'(32'(level_ff) * SLOTS_PER_LEVEL + 32'(scan_ff));
   assign query_idx  = IDX_W'(32'(level_ff) * SLOTS_PER_LEVEL + 32'(slot_ff));
   assign create_done = !level_ok || !alloc_ff[create_idx] || (scan_ff == SL_LAST);
   assign walk_end   = issue_done_ff && !proc_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (kind_type'(req_kind) == KIND_TICK) begin
                  state_in = ST_WALK;
               end else if (kind_type'(req_kind) == KIND_CREATE) begin
                  state_in = ST_CREATE;
               end else begin
                  state_in = ST_REPLY;
               end
            end
         end
         ST_WALK: begin
            if (walk_end) begin
               state_in = ST_IDLE;
            end
         end
         ST_CREATE: begin
            if (create_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_REPLY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and result outputs
   always_comb begin
      kind_in       = kind_ff;
      level_in      = level_ff;
      slot_in       = slot_ff;
      period_in     = period_ff;
      delay_in      = delay_ff;
      idx_in        = idx_ff;
      walk_lv_in    = walk_lv_ff;
      walk_sl_in    = walk_sl_ff;
      issue_done_in = issue_done_ff;
      proc_valid_in = 1'b0;
      proc_idx_in   = proc_idx_ff;
      proc_lv_in    = proc_lv_ff;
      proc_sl_in    = proc_sl_ff;
      pend_valid_in = pend_valid_ff;
      pend_lv_in    = pend_lv_ff;
      pend_sl_in    = pend_sl_ff;
      nrep_in       = nrep_ff;
      scan_in       = scan_ff;
      for (int e = 0; e < ENTRIES; e++) begin
         task_state_in[e] = task_state_ff[e];
         alloc_in[e]      = alloc_ff[e];
      end
      res_valid_in = 1'b0;
      res_fired_in = 1'b0;
      res_lv_in    = 2'd0;
      res_sl_in    = 2'd0;
      res_acc_in   = 1'b1;
      res_state_in = 2'd0;
      res_last_in  = 1'b0;
      mem_wr       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            // capture the transfer and clear the walk bookkeeping
            if (accept) begin
               kind_in       = kind_type'(req_kind);
               level_in      = req_level;
               slot_in       = req_slot;
               period_in     = req_period;
               delay_in      = req_initial_delay;
               idx_in        = '0;
               walk_lv_in    = '0;
               walk_sl_in    = '0;
               issue_done_in = 1'b0;
               pend_valid_in = 1'b0;
               nrep_in       = '0;
               scan_in       = '0;
            end
         end
         ST_WALK: begin
            // issue the next entry read
            if (!issue_done_ff) begin
               proc_valid_in = 1'b1;
               proc_idx_in   = idx_ff;
               proc_lv_in    = walk_lv_ff;
               proc_sl_in    = walk_sl_ff;
               idx_in        = idx_ff + IDX_W'(1);
               issue_done_in = (idx_ff == IDX_LAST);
               if (walk_sl_ff == SL_LAST) begin
                  walk_sl_in = '0;
                  walk_lv_in = walk_lv_ff + LV_W'(1);
               end else begin
                  walk_sl_in = walk_sl_ff + SL_W'(1);
               end
            end
            // update a ready entry and report a firing
            if (proc_valid_ff && (task_state_ff[proc_idx_ff] == TS_READY)) begin
               mem_wr.cd_en = 1'b1;
               mem_wr.addr  = ADDR_W'(proc_idx_ff);
               mem_wr.cd    = unit_next;
               if (unit_zero && (nrep_ff < NREP_MAX)) begin
                  if (pend_valid_ff) begin
                     res_valid_in = 1'b1;
                     res_fired_in = 1'b1;
                     res_lv_in    = 2'(pend_lv_ff);
                     res_sl_in    = 2'(pend_sl_ff);
                  end
                  pend_valid_in = 1'b1;
                  pend_lv_in    = proc_lv_ff;
                  pend_sl_in    = proc_sl_ff;
                  nrep_in       = nrep_ff + NREP_W'(1);
               end
            end
            // walk end: held firing goes out as last, or an empty report
            if (walk_end) begin
               res_valid_in = 1'b1;
               res_last_in  = 1'b1;
               if (pend_valid_ff) begin
                  res_fired_in = 1'b1;
                  res_lv_in    = 2'(pend_lv_ff);
                  res_sl_in    = 2'(pend_sl_ff);
               end
            end
         end
         ST_CREATE: begin
            // claim the first never allocated slot of the level
            if (!level_ok) begin
               res_valid_in = 1'b1;
               res_acc_in   = 1'b0;
               res_last_in  = 1'b1;
            end else if (!alloc_ff[create_idx]) begin
               alloc_in[create_idx]      = 1'b1;
               task_state_in[create_idx] = TS_READY;
               mem_wr.cd_en = 1'b1;
               mem_wr.rp_en = 1'b1;
               mem_wr.addr  = ADDR_W'(create_idx);
               mem_wr.cd    = delay_ff;
               mem_wr.rp    = period_ff;
               res_valid_in = 1'b1;
               res_last_in  = 1'b1;
            end else if (scan_ff == SL_LAST) begin
               res_valid_in = 1'b1;
               res_acc_in   = 1'b0;
               res_last_in  = 1'b1;
            end else begin
               scan_in = scan_ff + SL_W'(1);
            end
         end
         ST_REPLY: begin
            res_valid_in = 1'b1;
            res_last_in  = 1'b1;
            case (kind_ff)
               KIND_DELETE: begin
                  for (int e = 0; e < ENTRIES; e++) begin
                     if (level_ok && ((e / SLOTS_PER_LEVEL) == int'(level_ff))) begin
                        task_state_in[e] = TS_DELETED;
                     end
                  end
               end
               KIND_SUSPEND: begin
                  for (int e = 0; e < ENTRIES; e++) begin
                     if (level_ok && ((e / SLOTS_PER_LEVEL) == int'(level_ff))) begin
                        task_state_in[e] = TS_SUSPENDED;
                     end
                  end
               end
               KIND_RESUME: begin
                  for (int e = 0; e < ENTRIES; e++) begin
                     if (level_ok && ((e / SLOTS_PER_LEVEL) == int'(level_ff))
                         && alloc_ff[e]) begin
                        task_state_in[e] = TS_READY;
                     end
                  end
               end
               KIND_QUERY: begin
                  res_state_in = query_ok ? task_state_ff[query_idx] : TS_DELETED;
               end
               default: begin
                  // unknown kind changes nothing
                  res_acc_in = 1'b0;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_done_ff <= 1'b0;
         proc_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         nrep_ff       <= '0;
         res_valid_ff  <= 1'b0;
         for (int e = 0; e < ENTRIES; e++) begin
            task_state_ff[e] <= TS_DELETED;
            alloc_ff[e]      <= 1'b0;
         end
      end else begin
         state_ff      <= state_in;
         issue_done_ff <= issue_done_in;
         proc_valid_ff <= proc_valid_in;
         pend_valid_ff <= pend_valid_in;
         nrep_ff       <= nrep_in;
         res_valid_ff  <= res_valid_in;
         for (int e = 0; e < ENTRIES; e++) begin
            task_state_ff[e] <= task_state_in[e];
            alloc_ff[e]      <= alloc_in[e];
         end
      end
      kind_ff      <= kind_in;
      level_ff     <= level_in;
      slot_ff      <= slot_in;
      period_ff    <= period_in;
      delay_ff     <= delay_in;
      idx_ff       <= idx_in;
      walk_lv_ff   <= walk_lv_in;
      walk_sl_ff   <= walk_sl_in;
      proc_idx_ff  <= proc_idx_in;
      proc_lv_ff   <= proc_lv_in;
      proc_sl_ff   <= proc_sl_in;
      pend_lv_ff   <= pend_lv_in;
      pend_sl_ff   <= pend_sl_in;
      scan_ff      <= scan_in;
      res_fired_ff <= res_fired_in;
      res_lv_ff    <= res_lv_in;
      res_sl_ff    <= res_sl_in;
      res_acc_ff   <= res_acc_in;
      res_state_ff <= res_state_in;
      res_last_ff  <= res_last_in;
   end

   // result ports
   assign rsp_valid       = res_valid_ff;
   assign rsp_fired       = res_fired_ff;
   assign rsp_fired_level = res_lv_ff;
   assign rsp_fired_slot  = res_sl_ff;
   assign rsp_accepted    = res_acc_ff;
   assign rsp_slot_state  = res_state_ff;
   assign rsp_last        = res_last_ff;

endmodule

@@ tb/sv/periodic_task_tick_scheduler_core_tb.sv @@
// testbench for the periodic task tick scheduler: directed and random commands checked per result
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_core_tb
   import ptts_pkg::*;
;

   localparam int LEVELS       = DEFAULT_LEVELS;
   localparam int SLOTS        = DEFAULT_SLOTS;
   localparam int ENTRIES      = LEVELS * SLOTS;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 250;
   localparam int PAUSE_AT     = 120;
   localparam int DRAIN_CYCLES = 2 * ENTRIES + 8;
   localparam int STALL_LIMIT  = 1000;

   // kinds the block does not define
   localparam logic [2:0] KIND_RSVD_A = 3'd6;
   localparam logic [2:0] KIND_RSVD_B = 3'd7;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_kind;
   logic [1:0]  req_level;
   logic [1:0]  req_slot;
   logic [15:0] req_period;
   logic [15:0] req_initial_delay;
   logic        rsp_valid;
   logic        rsp_fired;
   logic [1:0]  rsp_fired_level;
   logic [1:0]  rsp_fired_slot;
   logic        rsp_accepted;
   logic [1:0]  rsp_slot_state;
   logic        rsp_last;

   typedef struct {
      logic       fired;
      logic [1:0] fired_level;
      logic [1:0] fired_slot;
      logic       accepted;
      logic [1:0] slot_state;
      logic       last;
   } sched_result_type;

   // task table shadow and the queue of results still owed by the block
   class sched_scoreboard;
      task_state_type   entry_state[ENTRIES];
      logic             entry_alloc[ENTRIES];
      logic [15:0]      entry_count[ENTRIES];
      logic [15:0]      entry_reload[ENTRIES];
      sched_result_type owed[$];
      int               errors;

      function new();
         for (int e = 0; e < ENTRIES; e++) begin
            entry_state[e]  = TS_DELETED;
            entry_alloc[e]  = 1'b0;
            entry_count[e]  = 16'd0;
            entry_reload[e] = 16'd0;
         end
         errors = 0;
      endfunction

      function int pending();
         return owed.size();
      endfunction

      // apply one accepted command to the shadow table and queue its results
      function void note_request(logic [2:0] kind, logic [1:0] lvl, logic [1:0] slt,
                                 logic [15:0] period, logic [15:0] delay);
         sched_result_type r;
         int               hits[$];
         int               e;
         bit               found;
         r = '{fired: 1'b0, fired_level: 2'd0, fired_slot: 2'd0,
               accepted: 1'b1, slot_state: TS_READY, last: 1'b1};
         found = 1'b0;
         case (kind) inside
            KIND_TICK: begin
               // walk level-major, fire on zero countdown and reload
               for (e = 0; e < ENTRIES; e++) begin
                  if (entry_state[e] != TS_READY) continue;
                  if (entry_count[e] == 16'd0) begin
                     entry_count[e] = entry_reload[e] - 16'd1;
                     if (hits.size() < MAX_RESULTS) hits.push_back(e);
                  end else begin
                     entry_count[e] = entry_count[e] - 16'd1;
                  end
               end
               if (hits.size() == 0) begin
                  owed.push_back(r);
               end else begin
                  foreach (hits[i]) begin
                     r.fired       = 1'b1;
                     r.fired_level = 2'(hits[i] / SLOTS);
                     r.fired_slot  = 2'(hits[i] % SLOTS);
                     r.last        = (i == hits.size() - 1);
                     owed.push_back(r);
                  end
               end
            end
            KIND_CREATE: begin
               // first never-allocated slot of the level, deleted slots stay taken
               r.accepted = 1'b0;
               for (int s = 0; s < SLOTS; s++) begin
                  e = lvl * SLOTS + s;
                  if (!found && !entry_alloc[e]) begin
                     entry_alloc[e]  = 1'b1;
                     entry_count[e]  = delay;
                     entry_reload[e] = period;
                     entry_state[e]  = TS_READY;
                     found           = 1'b1;
                  end
               end
               r.accepted = found;
               owed.push_back(r);
            end
            KIND_DELETE, KIND_SUSPEND, KIND_RESUME: begin
               for (int s = 0; s < SLOTS; s++) begin
                  e = lvl * SLOTS + s;
                  if (kind == KIND_DELETE) entry_state[e] = TS_DELETED;
                  else if (kind == KIND_SUSPEND) entry_state[e] = TS_SUSPENDED;
                  else if (entry_alloc[e]) entry_state[e] = TS_READY;
               end
               owed.push_back(r);
            end
            KIND_QUERY: begin
               r.slot_state = entry_state[lvl * SLOTS + slt];
               owed.push_back(r);
            end
            default: begin
               r.accepted = 1'b0;
               owed.push_back(r);
            end
         endcase
      endfunction

      // compare one result strobe with the oldest owed result
      function void check_response(sched_result_type got);
         sched_result_type want;
         if (owed.size() == 0) begin
            $error("unexpected result: fired %0d level %0d slot %0d", got.fired,
                   got.fired_level, got.fired_slot);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (got.fired !== want.fired) begin
            $error("fired: expected %0d, got %0d", want.fired, got.fired);
            errors++;
         end
         if (got.fired_level !== want.fired_level) begin
            $error("fired_level: expected %0d, got %0d", want.fired_level, got.fired_level);
            errors++;
         end
         if (got.fired_slot !== want.fired_slot) begin
            $error("fired_slot: expected %0d, got %0d", want.fired_slot, got.fired_slot);
            errors++;
         end
         if (got.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
            errors++;
         end
         if (got.slot_state !== want.slot_state) begin
            $error("slot_state: expected %0d, got %0d", want.slot_state, got.slot_state);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   sched_scoreboard sb = new();
   int              stall_cycles = 0;

   periodic_task_tick_scheduler_core #(
      .LEVELS          (LEVELS),
      .SLOTS_PER_LEVEL (SLOTS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_level         (req_level),
      .req_slot          (req_slot),
      .req_period        (req_period),
      .req_initial_delay (req_initial_delay),
      .rsp_valid         (rsp_valid),
      .rsp_fired         (rsp_fired),
      .rsp_fired_level   (rsp_fired_level),
      .rsp_fired_slot    (rsp_fired_slot),
      .rsp_accepted      (rsp_accepted),
      .rsp_slot_state    (rsp_slot_state),
      .rsp_last          (rsp_last)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // result monitor
   always @(posedge clock) begin
      sched_result_type got;
      if (!reset && rsp_valid === 1'b1) begin
         got.fired       = rsp_fired;
         got.fired_level = rsp_fired_level;
         got.fired_slot  = rsp_fired_slot;
         got.accepted    = rsp_accepted;
         got.slot_state  = rsp_slot_state;
         got.last        = rsp_last;
         sb.check_response(got);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // drive one command and hold it until the transfer, called at a falling edge
   task automatic send_item(input logic [2:0] kind, input logic [1:0] lvl,
                            input logic [1:0] slt, input logic [15:0] period,
                            input logic [15:0] delay);
      start             <= 1'b1;
      req_kind          <= kind;
      req_level         <= lvl;
      req_slot          <= slt;
      req_period        <= period;
      req_initial_delay <= delay;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(kind, lvl, slt, period, delay);
      @(negedge clock);
   endtask

   // sender gap with junk on the request fields
   task automatic idle_for(input int cycles);
      repeat (cycles) begin
         start             <= 1'b0;
         req_kind          <= 3'($urandom);
         req_level         <= 2'($urandom);
         req_slot          <= 2'($urandom);
         req_period        <= 16'($urandom);
         req_initial_delay <= 16'($urandom);
         @(negedge clock);
      end
   endtask

   // mostly short periods and delays so tasks fire often
   function automatic logic [15:0] pick_span(input int short_lo);
      int p;
      p = $urandom_range(0, 9);
      if (p < 7) return 16'($urandom_range(short_lo, 6));
      if (p < 9) return 16'($urandom_range(0, 40));
      return 16'($urandom);
   endfunction

   function automatic logic [2:0] pick_kind();
      int p;
      p = $urandom_range(0, 99);
      if (p < 45) return KIND_TICK;
      if (p < 57) return KIND_CREATE;
      if (p < 63) return KIND_DELETE;
      if (p < 73) return KIND_SUSPEND;
      if (p < 88) return KIND_RESUME;
      if (p < 97) return KIND_QUERY;
      return ($urandom_range(0, 1) != 0) ? KIND_RSVD_A : KIND_RSVD_B;
   endfunction

   // stimulus
   initial begin
      int          burst_left;
      logic [2:0]  kind;
      start             <= 1'b0;
      reset             <= 1'b1;
      req_kind          <= KIND_TICK;
      req_level         <= 2'd0;
      req_slot          <= 2'd0;
      req_period        <= 16'd0;
      req_initial_delay <= 16'd0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: fresh table, wrap of the reload, full level, level-wide state changes
      send_item(KIND_QUERY,   2'd0, 2'd0, 16'd0,     16'd0);
      send_item(KIND_TICK,    2'd0, 2'd0, 16'd0,     16'd0);
      send_item(KIND_CREATE,  2'd0, 2'd0, 16'd1,     16'd0);
      send_item(KIND_CREATE,  2'd0, 2'd0, 16'd0,     16'd0);
      send_item(KIND_CREATE,  2'd0, 2'd0, 16'hFFFF,  16'hFFFF);
      send_item(KIND_CREATE,  2'd0, 2'd0, 16'd3,     16'd1);
      send_item(KIND_CREATE,  2'd0, 2'd0, 16'd2,     16'd0);
      send_item(KIND_TICK,    2'd0, 2'd0, 16'd0,     16'd0);
      send_item(KIND_TICK,    2'd0, 2'd0, 16'd0,     16'd0);
      send_item(KIND_SUSPEND, 2'd0, 2'd0, 16'd0,     16'd0);
      send_item(KIND_QUERY,   2'd0, 2'd3, 16'd0,     16'd0);
      send_item(KIND_TICK,    2'd0, 2'd0, 16'd0,     16'd0);
      send_item(KIND_RESUME,  2'd0, 2'd0, 16'd0,     16'd0);
      // resume of a level with nothing allocated leaves it deleted
      send_item(KIND_RESUME,  2'd1, 2'd0, 16'd0,     16'd0);
      send_item(KIND_QUERY,   2'd1, 2'd2, 16'd0,     16'd0);
      send_item(KIND_DELETE,  2'd0, 2'd0, 16'd0,     16'd0);
      // deleted slots keep their allocation
      send_item(KIND_CREATE,  2'd0, 2'd0, 16'd1,     16'd0);
      send_item(KIND_QUERY,   2'd0, 2'd1, 16'd0,     16'd0);
      send_item(KIND_RSVD_A,  2'd3, 2'd3, 16'hFFFF,  16'hFFFF);
      send_item(KIND_RSVD_B,  2'd3, 2'd3, 16'hFFFF,  16'hFFFF);
      send_item(KIND_RESUME,  2'd0, 2'd0, 16'd0,     16'd0);
      send_item(KIND_TICK,    2'd0, 2'd0, 16'd0,     16'd0);
      send_item(KIND_CREATE,  2'd3, 2'd0, 16'd2,     16'd0);
      send_item(KIND_QUERY,   2'd3, 2'd0, 16'd0,     16'd0);
      send_item(KIND_TICK,    2'd0, 2'd0, 16'd0,     16'd0);

      // random commands in bursts with gaps
      burst_left = $urandom_range(1, 8);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == PAUSE_AT) begin
            // hold off until the block has answered everything
            while (sb.pending() != 0) idle_for(1);
         end
         if (burst_left == 0) begin
            idle_for($urandom_range(1, 20));
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
         end
         burst_left--;
         kind = pick_kind();
         if (kind == KIND_CREATE)
            send_item(kind, 2'($urandom), 2'($urandom), pick_span(1), pick_span(0));
         else
            send_item(kind, 2'($urandom), 2'($urandom), 16'($urandom), 16'($urandom));
      end

      // drain the owed results, then watch for stray strobes
      start <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
